>>> rtl/core/cdee_pkg.sv
// ----------------------------------------------------------------------------
// cdee_pkg
// Shared types and constants of the clock drift EMA estimator.
// ----------------------------------------------------------------------------
package cdee_pkg;

  localparam int TS_W    = 64;
  localparam int AGE_W   = 36;
  localparam int BASE_W  = 32;
  localparam int CLAMP_W = 15;
  localparam int DRIFT_W = 16;
  localparam int AVG_W   = 17;
  localparam int MAG_W   = 32;
  localparam int SCALE_W = 24;
  localparam int PROD_W  = MAG_W + SCALE_W;
  localparam int CNT_W   = $clog2(PROD_W);
  localparam int CFG_W   = AGE_W;
  localparam int IDX_W   = 2;

  localparam logic [SCALE_W-1:0] DRIFT_SCALE = SCALE_W'(10000000);
  localparam logic [MAG_W-1:0]   DIFF_LIMIT  = MAG_W'(64'h8000_0000);

  localparam logic [IDX_W-1:0] REG_MAX_AGE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MIN_BASE = 2'd1;
  localparam logic [IDX_W-1:0] REG_CLAMP    = 2'd2;
  localparam logic [IDX_W-1:0] REG_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic [TS_W-1:0] host_time_us;
    logic [TS_W-1:0] device_time_us;
  } in_t;

  typedef struct packed {
    logic signed [DRIFT_W-1:0] drift_ppm_x10;
    logic                      estimate_valid;
  } out_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic prune;
    logic base;
    logic diff;
    logic mul;
    logic div_step;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic multi;
    logic too_old;
    logic est_ok;
  } sts_t;

endpackage

>>> rtl/core/cdee_ctrl.sv
// ----------------------------------------------------------------------------
// cdee_ctrl
// Sequencer: write, prune walk, estimate, divide, average update, result.
// ----------------------------------------------------------------------------
module cdee_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cdee_pkg::cmd_t cmd,
  input  cdee_pkg::sts_t sts
);
  import cdee_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WRITE = 9'b000000010,
    S_RD    = 9'b000000100,
    S_CMP   = 9'b000001000,
    S_DIFF  = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_UPD   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovld_r, ovld_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r && !out_ready;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = sts.multi ? S_CMP : S_FIN;
      end
      S_CMP: begin
        if (sts.too_old) begin
          cmd.prune = 1'b1;
          state_nxt = S_RD;
        end else begin
          cmd.base  = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = sts.est_ok ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PROD_W - 1)) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!ovld_r || out_ready) begin
          cmd.load_out = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

>>> rtl/core/cdee_dpath.sv
// ----------------------------------------------------------------------------
// cdee_dpath
// Ring memory, config registers, divider and running average.
// ----------------------------------------------------------------------------
module cdee_dpath #(
  parameter int RING_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cdee_pkg::in_t                     in_data,
  output cdee_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [cdee_pkg::IDX_W-1:0]        cfg_index,
  input  logic [cdee_pkg::CFG_W-1:0]        cfg_wdata,
  input  cdee_pkg::cmd_t                    cmd,
  output cdee_pkg::sts_t                    sts
);
  import cdee_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int FIL_W = $clog2(RING_DEPTH + 1);

  logic [TS_W-1:0] host_mem [RING_DEPTH];
  logic [TS_W-1:0] dev_mem  [RING_DEPTH];

  logic [AGE_W-1:0]          max_age_r;
  logic [BASE_W-1:0]         min_base_r;
  logic [CLAMP_W-1:0]        clamp_r;
  logic signed [DRIFT_W-1:0] unknown_r;

  logic [TS_W-1:0]   host_r, dev_r, rd_host_r, rd_dev_r, ddev_r, hdiff_r;
  logic [PTR_W-1:0]  head_r, head_nxt, wr_ptr;
  logic [FIL_W-1:0]  fill_r, fill_nxt;
  logic [PTR_W:0]    wr_sum;
  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;
  logic [PROD_W-1:0] q_r;
  logic [TS_W-1:0]   rem_r;
  logic [TS_W:0]     trial, trial_sub;
  logic signed [AVG_W-1:0] avg_r;
  logic              have_r;
  out_t              out_r;

  logic [TS_W-1:0]   age, raw, raw_mag;
  logic [PROD_W-1:0] q_clamp;
  logic signed [AVG_W-1:0] inst;
  logic signed [AVG_W:0]   dlt, dlt_adj, avg_sum;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // write slot: old head when full (oldest is overwritten), else head+fill
  assign wr_sum = {1'b0, head_r} + (PTR_W + 1)'(fill_r);
  always_comb begin
    if (fill_r == FIL_W'(RING_DEPTH)) begin
      wr_ptr = head_r;
    end else if (wr_sum >= (PTR_W + 1)'(RING_DEPTH)) begin
      wr_ptr = PTR_W'(wr_sum - (PTR_W + 1)'(RING_DEPTH));
    end else begin
      wr_ptr = PTR_W'(wr_sum);
    end
  end

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cmd.write) begin
      if (fill_r == FIL_W'(RING_DEPTH)) head_nxt = ptr_inc(head_r);
      else fill_nxt = fill_r + 1'b1;
    end else if (cmd.prune) begin
      head_nxt = ptr_inc(head_r);
      fill_nxt = fill_r - 1'b1;
    end
  end

  assign age         = dev_r - rd_dev_r;
  assign sts.multi   = (fill_r > FIL_W'(1));
  assign sts.too_old = (age > TS_W'(max_age_r));
  assign sts.est_ok  = (ddev_r >= TS_W'(min_base_r)) && (ddev_r != '0);

  assign raw     = hdiff_r - ddev_r;
  assign raw_mag = raw[TS_W-1] ? (TS_W'(0) - raw) : raw;

  assign trial     = {rem_r, q_r[PROD_W-1]};
  assign trial_sub = trial - {1'b0, ddev_r};

  assign q_clamp = (q_r > PROD_W'(clamp_r)) ? PROD_W'(clamp_r) : q_r;
  assign inst    = neg_r ? -AVG_W'(q_clamp) : AVG_W'(q_clamp);
  assign dlt     = (AVG_W + 1)'(inst) - (AVG_W + 1)'(avg_r);
  // divide by four, truncating toward zero
  assign dlt_adj = $signed(dlt + (dlt[AVG_W] ? (AVG_W + 1)'(3) : (AVG_W + 1)'(0))) >>> 2;
  assign avg_sum = (AVG_W + 1)'(avg_r) + dlt_adj;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      host_mem[wr_ptr] <= host_r;
      dev_mem[wr_ptr]  <= dev_r;
    end
    rd_host_r <= host_mem[head_r];
    rd_dev_r  <= dev_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r  <= AGE_W'(64'd3600000000);
      min_base_r <= BASE_W'(64'd10000000);
      clamp_r    <= CLAMP_W'(32000);
      unknown_r  <= 16'sh8000;
      head_r     <= '0;
      fill_r     <= '0;
      avg_r      <= '0;
      have_r     <= 1'b0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_AGE:  max_age_r  <= cfg_wdata;
          REG_MIN_BASE: min_base_r <= cfg_wdata[BASE_W-1:0];
          REG_CLAMP:    clamp_r    <= cfg_wdata[CLAMP_W-1:0];
          REG_UNKNOWN:  unknown_r  <= cfg_wdata[DRIFT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        have_r <= 1'b1;
        avg_r  <= have_r ? AVG_W'(avg_sum) : inst;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      host_r <= in_data.host_time_us;
      dev_r  <= in_data.device_time_us;
    end
    if (cmd.base) begin
      ddev_r  <= age;
      hdiff_r <= host_r - rd_host_r;
    end
    if (cmd.diff) begin
      neg_r <= raw[TS_W-1];
      mag_r <= (raw_mag > TS_W'(DIFF_LIMIT)) ? DIFF_LIMIT : raw_mag[MAG_W-1:0];
    end
    if (cmd.mul) begin
      q_r   <= PROD_W'(mag_r) * PROD_W'(DRIFT_SCALE);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial_sub[TS_W]) begin
        rem_r <= trial_sub[TS_W-1:0];
        q_r   <= {q_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[TS_W-1:0];
        q_r   <= {q_r[PROD_W-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      out_r.estimate_valid <= have_r;
      out_r.drift_ppm_x10  <= have_r ? avg_r[DRIFT_W-1:0] : unknown_r;
    end
  end

  assign out_data = out_r;

endmodule

>>> rtl/core/clock_drift_ema_estimator_unit.sv
// ----------------------------------------------------------------------------
// clock_drift_ema_estimator_unit
// Host/device clock drift estimator with a pair ring and 1/4 EMA smoothing.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one beat carries one host and
//    device microsecond timestamp pair from the same sync instant.
//  - Output channel (out_valid/out_ready/out_data): exactly one beat per input
//    beat: smoothed drift in 0.1 ppm (or the unknown value) and a valid flag.
//  - Config port: cfg_we/cfg_index/cfg_wdata, write only, applied at the edge.
//    Index 0 max age, 1 min baseline, 2 clamp, 3 unknown value.
//  - Steps from an accepted beat to out_valid: write, ring read, a compare and
//    re-read per pruned pair, baseline, difference, multiply, the 56-step
//    restoring divider, average update and final load; with a single pair the
//    walk stops after the read, and a short baseline after the difference.
//  - One item is in work at a time; in_ready is high only while idle.
//  - The result sits in an output register, so the next beat is taken while
//    it waits; if the receiver still stalls when the next result is done, the
//    sequencer holds in its final state until the register frees.
//  - Reset (rst_n, synchronous) empties the ring, clears the average and
//    restores the register defaults.
// ----------------------------------------------------------------------------
module clock_drift_ema_estimator_unit #(
  parameter int RING_DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cdee_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cdee_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [cdee_pkg::IDX_W-1:0] cfg_index,
  input  logic [cdee_pkg::CFG_W-1:0] cfg_wdata
);
  import cdee_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  cdee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // ring, divider, average
  cdee_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // a taken beat starts work, so the input closes right after
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after a beat was taken");

  // reset leaves the block idle with no result pending
  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // a new result is only loaded once work on an item is done
  a_no_result_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.load_out)
    else $error("result loaded while idle");

endmodule
